@@ rtl/msps_pkg.sv @@
// ----------------------------------------------------------------------------
// msps_pkg
// Shared types and constants for the multi-stepper phase sequencer.
// ----------------------------------------------------------------------------
package msps_pkg;

    localparam int CHIPS_DEF  = 8;
    localparam int PHASES_DEF = 8;
    localparam int MPC        = 4;

    localparam int POS_W  = 18;
    localparam int WAIT_W = 9;
    localparam int REV_W  = 32;

    localparam logic [2:0] CMD_TICK  = 3'd0;
    localparam logic [2:0] CMD_SET   = 3'd1;
    localparam logic [2:0] CMD_ALL   = 3'd2;
    localparam logic [2:0] CMD_FORCE = 3'd3;
    localparam logic [2:0] CMD_STOP  = 3'd4;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_INDEX  = 2'd1;
    localparam logic [1:0] ST_HEIGHT = 2'd2;

    localparam logic [2:0] REG_STEP  = 3'd0;
    localparam logic [2:0] REG_BRAKE = 3'd1;
    localparam logic [2:0] REG_BTICK = 3'd2;
    localparam logic [2:0] REG_MAXH  = 3'd3;
    localparam logic [2:0] REG_COIL  = 3'd4;

    localparam logic [1:0] SM_HALF = 2'd0;
    localparam logic [1:0] SM_FULL = 2'd1;
    localparam logic [1:0] BM_TIMED = 2'd1;
    localparam logic [1:0] BM_HOLD  = 2'd2;

    // one motor's record in state memory
    typedef struct packed {
        logic signed [POS_W-1:0]  pos;
        logic signed [POS_W-1:0]  tgt;
        logic [2:0]               ph;
        logic signed [WAIT_W-1:0] wcnt;
        logic [7:0]               wrel;
        logic [7:0]               bcnt;
        logic [REV_W-1:0]         rev;
    } t_motor;

    typedef struct packed {
        logic [1:0]  step_mode;
        logic [1:0]  brake_mode;
        logic [7:0]  brake_ticks;
        logic [15:0] max_height;
        logic [31:0] coil_table;
    } t_cfg;

endpackage

@@ rtl/multi_stepper_phase_sequencer.sv @@
// ----------------------------------------------------------------------------
// multi_stepper_phase_sequencer
// Step/brake sequencer for CHIPS*4 stepper motors, state kept in one memory.
// ----------------------------------------------------------------------------
// Motor state sits in a single-port-write, registered-read memory of CHIPS*4
// records, cleared after reset by a pass that writes each record in turn (no
// requests taken meanwhile). Tick, set all and stop walk every motor once,
// one read-modify-write per cycle unless held at a chip boundary; set one and
// force update a single record. A tick emits one coil word per chip as each
// group of four motors completes; a single output register holds results, so
// the walk pauses while a result waits to be taken.
module multi_stepper_phase_sequencer
    import msps_pkg::*;
#(
    parameter int CHIPS  = CHIPS_DEF,
    parameter int PHASES = PHASES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_mode,
    input  logic [5:0]  i_stepper_index,
    input  logic [31:0] i_revision,
    input  logic [15:0] i_height,
    input  logic [7:0]  i_wait_time,
    input  logic        i_half_only,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_kind,
    output logic [1:0]  o_status,
    output logic [2:0]  o_chip,
    output logic [15:0] o_coil_word,
    output logic        o_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int MOTORS = CHIPS * MPC;
    localparam int MW     = $clog2(MOTORS);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_RUN   = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    t_cfg r_cfg;
    logic [2:0] r_state, n_state;
    logic [MW:0] r_cnt, n_cnt;
    logic [2:0]  r_mode;
    logic [MW-1:0] r_idx;
    logic [31:0] r_rev;
    logic [15:0] r_h;
    logic [7:0]  r_wt;
    logic        r_half;
    logic [1:0]  r_st;
    logic [15:0] r_word, n_word;

    t_motor mem [MOTORS];
    t_motor r_rd;
    logic          mem_we;
    logic [MW-1:0] mem_wa, mem_ra;
    t_motor        mem_wd;

    logic        r_ov;
    logic        r_kind;
    logic [1:0]  r_ost;
    logic [2:0]  r_ochip;
    logic [15:0] r_oword;
    logic        r_olast;

    // ---- config port ----
    logic [2:0] reg_sel;
    assign reg_sel = paddr[4:2];
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.step_mode   <= 2'd2;
            r_cfg.brake_mode  <= 2'd0;
            r_cfg.brake_ticks <= 8'd0;
            r_cfg.max_height  <= 16'hFFFF;
            r_cfg.coil_table  <= 32'h98C4A231;
        end else if (psel && penable && pwrite) begin
            unique case (reg_sel)
                REG_STEP:  r_cfg.step_mode   <= pwdata[1:0];
                REG_BRAKE: r_cfg.brake_mode  <= pwdata[1:0];
                REG_BTICK: r_cfg.brake_ticks <= pwdata[7:0];
                REG_MAXH:  r_cfg.max_height  <= pwdata[15:0];
                REG_COIL:  r_cfg.coil_table  <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_STEP:  prdata = {30'd0, r_cfg.step_mode};
            REG_BRAKE: prdata = {30'd0, r_cfg.brake_mode};
            REG_BTICK: prdata = {24'd0, r_cfg.brake_ticks};
            REG_MAXH:  prdata = {16'd0, r_cfg.max_height};
            REG_COIL:  prdata = r_cfg.coil_table;
            default:   prdata = 32'd0;
        endcase
    end

    // ---- request decode ----
    logic acc;
    logic valid_cmd;
    logic idx_bad;
    logic h_bad;
    logic walk;
    assign o_ready   = (r_state == S_IDLE) && !r_ov;
    assign acc       = i_valid && o_ready;
    assign valid_cmd = (i_mode <= CMD_STOP);
    assign idx_bad   = ({26'd0, i_stepper_index} >= 32'(MOTORS));
    assign h_bad     = (i_height > r_cfg.max_height);
    assign walk      = (r_mode == CMD_TICK) || (r_mode == CMD_ALL) || (r_mode == CMD_STOP);

    // ---- memory ----
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rd <= mem[mem_ra];
    end

    // address of the record being processed this cycle, and the one to fetch
    logic [MW-1:0] cur;
    assign cur = walk ? r_cnt[MW-1:0] : r_idx;

    // no forwarding needed: the walk reads m+1 while writing m, never the same entry
    logic ready_adv;
    logic out_free;
    assign out_free = !r_ov || i_ready;

    // ---- per-motor update ----
    t_motor m_in, m_out;
    logic [3:0] pat;
    logic       on;
    logic signed [POS_W:0] diff;
    logic [POS_W:0]        adiff;
    logic [1:0] sz;
    logic       waiting;
    logic [3:0] ph4;
    logic       newer;
    logic [31:0] rdiff;
    logic [1:0]  smode;

    assign m_in  = r_rd;
    assign smode = (r_cfg.step_mode == 2'd3) ? 2'd2 : r_cfg.step_mode;
    assign rdiff = r_rev - m_in.rev;
    assign newer = (rdiff != 32'd0) && !rdiff[31];

    always_comb begin
        m_out   = m_in;
        on      = 1'b0;
        sz      = 2'd0;
        waiting = 1'b0;
        ph4     = {1'b0, m_in.ph};
        diff    = (POS_W+1)'(m_in.tgt) - (POS_W+1)'(m_in.pos);
        adiff   = diff[POS_W] ? (POS_W+1)'(-diff) : (POS_W+1)'(diff);
        pat     = 4'd0;
        unique case (r_mode)
            CMD_TICK: begin
                if (adiff != '0) begin
                    if (smode == SM_HALF) begin
                        sz = 2'd1;
                    end else if (smode == SM_FULL) begin
                        sz = (adiff >= 2) ? 2'd2 : 2'd0;
                    end else begin
                        sz = (adiff >= 2) ? 2'd2 : 2'd1;
                    end
                end
                if (r_half && sz == 2'd2) sz = 2'd1;
                if (m_in.wrel != 8'd0) begin
                    if (m_in.wcnt != -9'sd1) m_out.wcnt = m_in.wcnt - 9'sd1;
                    waiting = !m_out.wcnt[WAIT_W-1];
                end
                if (sz != 2'd0 && !waiting) begin
                    if (sz == 2'd2 && m_in.ph[0]) sz = 2'd1;
                    if (m_in.tgt < m_in.pos) begin
                        m_out.pos = m_in.pos - POS_W'(sz);
                        if ({2'b00, sz} > ph4) begin
                            ph4 = 4'(PHASES) - {2'b00, sz};
                        end else begin
                            ph4 = ph4 - {2'b00, sz};
                        end
                    end else begin
                        m_out.pos = m_in.pos + POS_W'(sz);
                        ph4 = ph4 + {2'b00, sz};
                        if (ph4 >= 4'(PHASES)) ph4 = 4'd0;
                    end
                    m_out.ph   = ph4[2:0];
                    on         = 1'b1;
                    m_out.wcnt = $signed({1'b0, m_in.wrel});
                    m_out.bcnt = 8'd0;
                end else if (r_cfg.brake_mode == BM_TIMED) begin
                    if (m_in.bcnt < r_cfg.brake_ticks) begin
                        on         = 1'b1;
                        m_out.bcnt = m_in.bcnt + 8'd1;
                    end
                end else if (r_cfg.brake_mode == BM_HOLD) begin
                    on = 1'b1;
                end
            end
            CMD_SET, CMD_ALL: begin
                if (r_st == ST_OK && newer) begin
                    m_out.rev  = r_rev;
                    m_out.tgt  = POS_W'(r_h);
                    m_out.wcnt = '0;
                    m_out.wrel = r_wt;
                end
            end
            CMD_FORCE: begin
                m_out.pos  = '0;
                m_out.wcnt = '0;
                m_out.wrel = '0;
                m_out.bcnt = '0;
                m_out.rev  = r_rev;
                m_out.tgt  = POS_W'($signed(r_h));
            end
            CMD_STOP: begin
                m_out.tgt  = m_in.pos;
                m_out.wcnt = '0;
            end
            default: ;
        endcase
        if (on) pat = r_cfg.coil_table[{m_out.ph, 2'b00} +: 4];
    end

    // ---- control ----
    logic last_m;
    logic grp_end;
    assign last_m  = (r_cnt[MW-1:0] == MW'(MOTORS - 1));
    assign grp_end = (r_cnt[1:0] == 2'd3);
    // a tick's chip boundary needs the output register free
    assign ready_adv = (r_mode != CMD_TICK) || !grp_end || out_free;

    logic emit_tick;
    logic emit_stat;

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_word    = r_word;
        mem_we    = 1'b0;
        mem_wa    = cur;
        mem_wd    = m_out;
        mem_ra    = cur;
        emit_tick = 1'b0;
        emit_stat = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
                mem_wa = r_cnt[MW-1:0];
                mem_wd = '0;
                n_cnt  = r_cnt + 1'b1;
                if (last_m) begin
                    n_state = S_IDLE;
                    n_cnt   = '0;
                end
            end
            S_IDLE: begin
                mem_ra = (i_mode == CMD_SET || i_mode == CMD_FORCE)
                         ? i_stepper_index[MW-1:0] : MW'(0);
                n_cnt  = '0;
                n_word = '0;
                if (acc && valid_cmd) begin
                    if ((i_mode == CMD_SET || i_mode == CMD_FORCE) && idx_bad) begin
                        n_state = S_DONE;
                    end else if ((i_mode == CMD_SET || i_mode == CMD_ALL) && h_bad) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_RUN;
                    end
                end
            end
            S_READ: begin
                n_state = S_RUN;
            end
            S_RUN: begin
                if (ready_adv) begin
                    mem_we = 1'b1;
                    n_word = r_word | (16'(pat) << {r_cnt[1:0], 2'b00});
                    if (r_mode == CMD_TICK && grp_end) begin
                        emit_tick = 1'b1;
                        n_word    = '0;
                    end
                    if (!walk || last_m) begin
                        n_state = (r_mode == CMD_TICK) ? S_IDLE : S_DONE;
                    end else begin
                        n_cnt   = r_cnt + 1'b1;
                        mem_ra  = r_cnt[MW-1:0] + 1'b1;
                        n_state = S_RUN;
                    end
                end else begin
                    // hold: re-read same record to keep r_rd
                    mem_ra = cur;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    emit_stat = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_cnt   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (emit_tick || emit_stat) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    logic [1:0] st_new;
    assign st_new = ((i_mode == CMD_SET || i_mode == CMD_FORCE) && idx_bad) ? ST_INDEX :
                    ((i_mode == CMD_SET || i_mode == CMD_ALL) && h_bad) ? ST_HEIGHT : ST_OK;

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
        if (acc) begin
            r_mode <= i_mode;
            r_idx  <= i_stepper_index[MW-1:0];
            r_rev  <= i_revision;
            r_h    <= i_height;
            r_wt   <= i_wait_time;
            r_half <= i_half_only;
            r_st   <= st_new;
        end
        if (emit_tick) begin
            r_kind  <= 1'b1;
            r_ost   <= ST_OK;
            r_ochip <= 3'(r_cnt[MW-1:2]);
            r_oword <= r_word | (16'(pat) << {r_cnt[1:0], 2'b00});
            r_olast <= last_m;
        end else if (emit_stat) begin
            r_kind  <= 1'b0;
            r_ost   <= r_st;
            r_ochip <= 3'd0;
            r_oword <= 16'd0;
            r_olast <= 1'b1;
        end
    end

    assign o_valid     = r_ov;
    assign o_kind      = r_kind;
    assign o_status    = r_ost;
    assign o_chip      = r_ochip;
    assign o_coil_word = r_oword;
    assign o_last      = r_olast;

`ifndef SYNTH
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> !o_ready) else $error("request taken while busy");
    a_tick_out_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit_tick |=> (o_valid && o_kind)) else $error("tick result lost");
    a_hold_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> o_valid) else $error("result dropped");
`endif

endmodule
